[rtl/alr_pkg.sv]
// ----------------------------------------------------------------------------
// alr_pkg
// Shared constants, payload types and register codes for the anti-aliased
// line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package alr_pkg;

    localparam int TILE_SIZE = 32;
    localparam int FRAC_BITS = 16;

    localparam int COORD_W   = 5;
    localparam int COLOUR_W  = 8;
    localparam int LIM_W     = COORD_W + 1;
    localparam int MINOR_W   = LIM_W + 1;
    localparam int DIV_W     = FRAC_BITS + COORD_W;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int GRAD_W    = DIV_W + 1;
    localparam int INTERY_W  = GRAD_W + 1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [LIM_W-1:0] TILE_LIMIT = LIM_W'(TILE_SIZE);
    localparam logic [LIM_W-1:0] CFG_RESET  = LIM_W'(32);

    localparam int JQ_DEPTH  = 2;
    localparam int JQ_PTR_W  = $clog2(JQ_DEPTH);
    localparam int JQ_CNT_W  = $clog2(JQ_DEPTH + 1);
    localparam int OQ_DEPTH  = 2;
    localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_W-1:0]  x_start;
        logic [COORD_W-1:0]  y_start;
        logic [COORD_W-1:0]  x_end;
        logic [COORD_W-1:0]  y_end;
        logic [COLOUR_W-1:0] red_in;
        logic [COLOUR_W-1:0] green_in;
        logic [COLOUR_W-1:0] blue_in;
        logic [COLOUR_W-1:0] alpha_in;
    } t_line;

    typedef struct packed {
        logic [COORD_W-1:0]  pixel_x;
        logic [COORD_W-1:0]  pixel_y;
        logic [COLOUR_W-1:0] red_out;
        logic [COLOUR_W-1:0] green_out;
        logic [COLOUR_W-1:0] blue_out;
        logic [COLOUR_W-1:0] alpha_out;
        logic                last_fragment;
    } t_frag;

    typedef struct packed {
        logic [LIM_W-1:0] width_in_use;
        logic [LIM_W-1:0] height_in_use;
    } t_cfg;

    // line in drawing frame: x is the major axis, x0 <= x1
    typedef struct packed {
        logic                     steep;
        logic [COORD_W-1:0]       x0;
        logic [COORD_W-1:0]       y0;
        logic [COORD_W-1:0]       x1;
        logic [COORD_W-1:0]       y1;
        logic signed [GRAD_W-1:0] grad;
        logic [COLOUR_W-1:0]      red;
        logic [COLOUR_W-1:0]      green;
        logic [COLOUR_W-1:0]      blue;
        logic [COLOUR_W-1:0]      alpha;
    } t_job;

endpackage

`default_nettype wire

[rtl/antialiased_line_rasterizer.sv]
// Setup: a single-point line goes straight to the push state; any other
//   line first runs a bit-serial gradient divide, then enters the line queue.
// Back end: it takes the line, makes two candidate fragments per endpoint,
//   then two per span column, and closes the line; a full result queue stalls
//   it. Setup of the next line overlaps through a two-entry line queue.
// Reset: synchronous, active low; queues empty, registers at 32 columns/rows.
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer
// Wu anti-aliased line fragments for one square tile, queue interfaces and
// APB configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module antialiased_line_rasterizer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [alr_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [alr_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [alr_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    input  wire logic                           push,
    output logic                                full,
    input  wire alr_pkg::t_line                 i_line,
    output logic                                empty,
    input  wire logic                           pop,
    output alr_pkg::t_frag                      o_frag
);
    import alr_pkg::*;

    t_cfg cfg;
    t_job f_job, q_job;
    logic f_push, q_full, q_pop, q_empty;

    alr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    alr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_line     (i_line),
        .o_job_push (f_push),
        .i_job_full (q_full),
        .o_job      (f_job)
    );

    alr_job_queue u_jq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_job   (f_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    alr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_empty (q_empty),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .empty       (empty),
        .pop         (pop),
        .o_frag      (o_frag)
    );

endmodule

`default_nettype wire

[rtl/alr_cfg.sv]
// ----------------------------------------------------------------------------
// alr_cfg
// APB register file: tile width and height in use.
// ----------------------------------------------------------------------------
`default_nettype none

module alr_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [alr_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [alr_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [alr_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output alr_pkg::t_cfg                       o_cfg
);
    import alr_pkg::*;

    logic [LIM_W-1:0] r_width;
    logic [LIM_W-1:0] r_height;
    t_cfg_idx         idx;
    logic             wr_en;

    assign idx    = t_cfg_idx'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_RESET;
            r_height <= CFG_RESET;
        end else if (wr_en) begin
            case (idx)
                CFG_WIDTH:  r_width  <= pwdata[LIM_W-1:0];
                CFG_HEIGHT: r_height <= pwdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            CFG_WIDTH:  prdata = {{(APB_DATA_W-LIM_W){1'b0}}, r_width};
            CFG_HEIGHT: prdata = {{(APB_DATA_W-LIM_W){1'b0}}, r_height};
            default:    prdata = '0;
        endcase
    end

    assign o_cfg.width_in_use  = r_width;
    assign o_cfg.height_in_use = r_height;

endmodule

`default_nettype wire

[rtl/alr_front.sv]
// ----------------------------------------------------------------------------
// alr_front
// Line setup: steep test, endpoint ordering and a bit-serial gradient divide.
// ----------------------------------------------------------------------------
`default_nettype none

module alr_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire alr_pkg::t_line i_line,
    output logic               o_job_push,
    input  wire logic          i_job_full,
    output alr_pkg::t_job      o_job
);
    import alr_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate                r_state, n_state;
    t_job                   r_job;
    logic                   r_neg;
    logic [COORD_W-1:0]     r_den;
    logic [DIV_W-1:0]       r_quo;
    logic [COORD_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0]   r_cnt;

    logic                   accept;
    logic [COORD_W-1:0]     adx, ady;
    logic                   steep;
    logic [COORD_W-1:0]     sx0, sy0, sx1, sy1;
    logic                   swap;
    t_job                   n_job;
    logic [COORD_W-1:0]     n_dx, n_ady;
    logic                   n_neg;

    logic [COORD_W:0]       trial, diff;
    logic                   ge;
    logic [COORD_W-1:0]     n_rem;
    logic [DIV_W-1:0]       n_quo;
    logic signed [GRAD_W-1:0] quo_mag;
    logic                   last_step;

    assign accept     = push & ~full;
    assign full       = (r_state != F_IDLE);
    assign o_job_push = (r_state == F_PUSH);
    assign o_job      = r_job;

    always_comb begin
        adx   = (i_line.x_end >= i_line.x_start) ? i_line.x_end - i_line.x_start
                                                 : i_line.x_start - i_line.x_end;
        ady   = (i_line.y_end >= i_line.y_start) ? i_line.y_end - i_line.y_start
                                                 : i_line.y_start - i_line.y_end;
        steep = ady > adx;
        sx0   = steep ? i_line.y_start : i_line.x_start;
        sy0   = steep ? i_line.x_start : i_line.y_start;
        sx1   = steep ? i_line.y_end   : i_line.x_end;
        sy1   = steep ? i_line.x_end   : i_line.y_end;
        swap  = sx0 > sx1;

        n_job       = '0;
        n_job.steep = steep;
        n_job.x0    = swap ? sx1 : sx0;
        n_job.y0    = swap ? sy1 : sy0;
        n_job.x1    = swap ? sx0 : sx1;
        n_job.y1    = swap ? sy0 : sy1;
        n_job.red   = i_line.red_in;
        n_job.green = i_line.green_in;
        n_job.blue  = i_line.blue_in;
        n_job.alpha = i_line.alpha_in;

        n_dx  = n_job.x1 - n_job.x0;
        n_neg = n_job.y1 < n_job.y0;
        n_ady = n_neg ? n_job.y0 - n_job.y1 : n_job.y1 - n_job.y0;
    end

    // restoring divide, one quotient bit per cycle
    always_comb begin
        trial     = {r_rem, r_quo[DIV_W-1]};
        diff      = trial - {1'b0, r_den};
        ge        = trial >= {1'b0, r_den};
        n_rem     = ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
        n_quo     = {r_quo[DIV_W-2:0], ge};
        quo_mag   = signed'({1'b0, n_quo});
        last_step = (r_cnt == DIV_CNT_W'(DIV_W - 1));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: if (accept) begin
                n_state = (n_dx == '0) ? F_PUSH : F_DIV;
            end
            F_DIV: if (last_step) begin
                n_state = F_PUSH;
            end
            F_PUSH: if (!i_job_full) begin
                n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: if (accept) begin
                r_job <= n_job;
                r_neg <= n_neg;
                r_den <= n_dx;
                r_quo <= {n_ady, {FRAC_BITS{1'b0}}};
                r_rem <= '0;
                r_cnt <= '0;
            end
            F_DIV: begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (last_step) begin
                    r_job.grad <= r_neg ? -quo_mag : quo_mag;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[rtl/alr_job_queue.sv]
// ----------------------------------------------------------------------------
// alr_job_queue
// Two-entry queue of set-up lines between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module alr_job_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire alr_pkg::t_job i_job,
    output logic           o_full,
    input  wire logic      i_pop,
    output logic           o_empty,
    output alr_pkg::t_job  o_job
);
    import alr_pkg::*;

    t_job                r_mem [JQ_DEPTH];
    logic [JQ_PTR_W-1:0] r_wp, r_rp;
    logic [JQ_CNT_W-1:0] r_cnt;
    logic                do_push, do_pop;

    assign o_full  = (r_cnt == JQ_CNT_W'(JQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == JQ_PTR_W'(JQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == JQ_PTR_W'(JQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + JQ_CNT_W'(do_push) - JQ_CNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

`default_nettype wire

[rtl/alr_back.sv]
// ----------------------------------------------------------------------------
// alr_back
// Fragment walker: endpoint pairs then span columns, bounds clip, one-deep
// hold-back to mark the final fragment, and a two-entry result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module alr_back (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire alr_pkg::t_cfg i_cfg,
    input  wire logic      i_job_empty,
    input  wire alr_pkg::t_job i_job,
    output logic           o_job_pop,
    output logic           empty,
    input  wire logic      pop,
    output alr_pkg::t_frag o_frag
);
    import alr_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_ENDS  = 4'b0010,
        B_SPAN  = 4'b0100,
        B_FLUSH = 4'b1000
    } t_bstate;

    t_bstate                    r_state, n_state;
    t_job                       r_job;
    logic [1:0]                 r_idx;
    logic                       r_half;
    logic [LIM_W-1:0]           r_x;
    logic signed [INTERY_W-1:0] r_intery;
    logic                       r_pend_v;
    t_frag                      r_pend;

    t_frag                      r_oq [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]        r_oq_wp, r_oq_rp;
    logic [OQ_CNT_W-1:0]        r_oq_cnt;
    logic                       oq_full, oq_push, oq_pop;
    t_frag                      oq_data;

    logic [LIM_W-1:0]           lim_w, lim_h;
    logic signed [INTERY_W-1:0] grad_ext, intery_init;
    logic [INTERY_W-1:0]        u;
    logic [FRAC_BITS-1:0]       f;
    logic [LIM_W-1:0]           ip;
    logic [FRAC_BITS:0]         one_minus_f;
    logic [FRAC_BITS+COLOUR_W:0]   prod_r;
    logic [FRAC_BITS+COLOUR_W-1:0] prod_f;
    logic [LIM_W-1:0]           major;
    logic [MINOR_W-1:0]         minor;
    logic [COLOUR_W-1:0]        alpha;
    logic [MINOR_W-1:0]         px, py;
    logic                       gen, cand_ok;
    t_frag                      cand;
    logic [LIM_W-1:0]           x0p1, xn;

    assign o_job_pop = (r_state == B_IDLE) & ~i_job_empty;
    assign gen       = ((r_state == B_ENDS) | (r_state == B_SPAN)) & ~oq_full;

    always_comb begin
        lim_w = (i_cfg.width_in_use  > TILE_LIMIT) ? TILE_LIMIT : i_cfg.width_in_use;
        lim_h = (i_cfg.height_in_use > TILE_LIMIT) ? TILE_LIMIT : i_cfg.height_in_use;

        grad_ext    = INTERY_W'(r_job.grad);
        intery_init = signed'({{(INTERY_W-COORD_W-FRAC_BITS){1'b0}}, r_job.y0,
                               {FRAC_BITS{1'b0}}}) + grad_ext;
        u           = r_intery[INTERY_W-1] ? '0 : unsigned'(r_intery);
        f           = u[FRAC_BITS-1:0];
        ip          = u[FRAC_BITS+LIM_W-1:FRAC_BITS];
        one_minus_f = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, f};
        prod_r      = one_minus_f * r_job.alpha;
        prod_f      = f * r_job.alpha;

        x0p1 = {1'b0, r_job.x0} + 1'b1;
        xn   = r_x + 1'b1;

        major = '0;
        minor = '0;
        alpha = '0;
        case (r_state)
            B_ENDS: begin
                major = {1'b0, r_idx[1] ? r_job.x1 : r_job.x0};
                minor = {2'b00, r_idx[1] ? r_job.y1 : r_job.y0} + MINOR_W'(r_idx[0]);
                alpha = r_idx[0] ? '0 : r_job.alpha >> 1;
            end
            B_SPAN: begin
                major = r_x;
                minor = {1'b0, ip} + MINOR_W'(r_half);
                alpha = r_half ? prod_f[FRAC_BITS+COLOUR_W-1:FRAC_BITS]
                               : prod_r[FRAC_BITS+COLOUR_W-1:FRAC_BITS];
            end
            default: ;
        endcase

        px      = r_job.steep ? minor : {1'b0, major};
        py      = r_job.steep ? {1'b0, major} : minor;
        cand_ok = (px < {1'b0, lim_w}) && (py < {1'b0, lim_h});

        cand.pixel_x       = px[COORD_W-1:0];
        cand.pixel_y       = py[COORD_W-1:0];
        cand.red_out       = r_job.red;
        cand.green_out     = r_job.green;
        cand.blue_out      = r_job.blue;
        cand.alpha_out     = alpha;
        cand.last_fragment = 1'b0;
    end

    always_comb begin
        oq_push = 1'b0;
        oq_data = r_pend;
        if (gen && cand_ok && r_pend_v) begin
            oq_push = 1'b1;
        end else if ((r_state == B_FLUSH) && !oq_full && r_pend_v) begin
            oq_push               = 1'b1;
            oq_data.last_fragment = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: if (!i_job_empty) begin
                n_state = B_ENDS;
            end
            B_ENDS: if (gen && (r_idx == 2'd3)) begin
                n_state = (x0p1 < {1'b0, r_job.x1}) ? B_SPAN : B_FLUSH;
            end
            B_SPAN: if (gen && r_half && !(xn < {1'b0, r_job.x1})) begin
                n_state = B_FLUSH;
            end
            B_FLUSH: if (!oq_full) begin
                n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_pend_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (gen && cand_ok) begin
                r_pend_v <= 1'b1;
            end else if ((r_state == B_FLUSH) && !oq_full) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (gen && cand_ok) begin
            r_pend <= cand;
        end
        case (r_state)
            B_IDLE: begin
                r_job  <= i_job;
                r_idx  <= '0;
                r_half <= 1'b0;
            end
            B_ENDS: if (gen) begin
                r_idx    <= r_idx + 1'b1;
                r_x      <= x0p1;
                r_intery <= intery_init;
            end
            B_SPAN: if (gen) begin
                r_half <= ~r_half;
                if (r_half) begin
                    r_x      <= xn;
                    r_intery <= r_intery + grad_ext;
                end
            end
            default: ;
        endcase
    end

    // result queue
    assign oq_full = (r_oq_cnt == OQ_CNT_W'(OQ_DEPTH));
    assign empty   = (r_oq_cnt == '0);
    assign oq_pop  = pop & ~empty;
    assign o_frag  = r_oq[r_oq_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (oq_push) begin
                r_oq_wp <= (r_oq_wp == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : r_oq_wp + 1'b1;
            end
            if (oq_pop) begin
                r_oq_rp <= (r_oq_rp == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : r_oq_rp + 1'b1;
            end
            r_oq_cnt <= r_oq_cnt + OQ_CNT_W'(oq_push) - OQ_CNT_W'(oq_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_oq_wp] <= oq_data;
        end
    end

    a_no_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_IDLE) |-> !r_pend_v)
        else $error("held fragment left over after line end");

    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oq_cnt <= OQ_CNT_W'(OQ_DEPTH))
        else $error("result queue overrun");

    a_span_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_SPAN) |-> ((r_x < {1'b0, r_job.x1}) && (r_x > {1'b0, r_job.x0})))
        else $error("span column outside endpoints");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == B_FLUSH) && !oq_full && r_pend_v) |=> !empty)
        else $error("final fragment not queued");

endmodule

`default_nettype wire
